// File: rtl/ffdsc_pkg.sv
// ----------------------------------------------------------------------------
// ffdsc_pkg
// Shared types and constants for the fixed-length frame deframer.
// ----------------------------------------------------------------------------
package ffdsc_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned IndexW = 7;

  localparam logic [ByteW-1:0]  SyncByte  = 8'h55;
  localparam logic [IndexW-1:0] SumEnd    = 7'd62;
  localparam logic [IndexW-1:0] LastIndex = 7'd64;
  localparam logic [IndexW-1:0] CmdIndex  = 7'd9;
  localparam logic [IndexW-1:0] HdrFirst  = 7'd2;
  localparam logic [IndexW-1:0] HdrLast   = 7'd7;

  typedef enum logic [2:0] {
    StRun     = 3'd0,
    StGood    = 3'd1,
    StHeader  = 3'd2,
    StTrailer = 3'd3,
    StCheck   = 3'd4
  } frame_status_e;

  // One result item as produced by the parser.
  typedef struct packed {
    logic                emit;
    logic [ByteW-1:0]    data;
    logic [IndexW-1:0]   index;
    logic                frame_end;
    frame_status_e       status;
    logic [ByteW-1:0]    command;
  } result_t;

  // Expected header byte at indices 2..7.
  function automatic logic [ByteW-1:0] header_byte(input logic [IndexW-1:0] pos);
    logic [ByteW-1:0] val;
    case (pos)
      7'd2:    val = 8'd1;
      7'd3:    val = 8'd0;
      7'd4:    val = 8'd1;
      7'd5:    val = 8'd0;
      7'd6:    val = 8'd0;
      7'd7:    val = 8'd2;
      default: val = 8'd0;
    endcase
    return val;
  endfunction

endpackage

// File: rtl/fixed_frame_deframer_sum_check.sv
// ----------------------------------------------------------------------------
// fixed_frame_deframer_sum_check
// Deframer for 65-byte frames with fixed header, 8-bit additive checksum
// and sync trailer.
// ----------------------------------------------------------------------------
// Takes one received byte per transfer and sustains one byte per clock
// while the output is not stalled. Each byte passes through an input
// register, combinational parse logic (compare plus 8-bit add) and a
// result register, from which the result is presented and transfers
// when the output is not stalled. Bytes outside a frame
// that are not 0x55 are dropped silently.
// Every byte inside a frame comes out with its index 0..64; the byte that
// ends a frame carries frame_end and the status (good, bad trailer, bad
// checksum, reported at index 64, together with the command byte from
// index 9), and a wrong byte at header indices 2..7 aborts the frame with
// header-mismatch status and restarts the hunt with the next byte.
// Stall on the input side rises only while both registers are full and
// the output side is stalling.
module fixed_frame_deframer_sum_check import ffdsc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // receive side
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [ByteW-1:0]  rx_byte_i,
  // result side
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ByteW-1:0]  data_byte_o,
  output logic [IndexW-1:0] byte_index_o,
  output logic              frame_end_o,
  output logic [2:0]        frame_status_o,
  output logic [ByteW-1:0]  command_code_o
);

  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             out_valid_q;
  result_t          res_q;
  result_t          res;
  logic             out_free;
  logic             fire;

  // result register can take a new value when empty or being drained
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_byte_q <= rx_byte_i;
    end
  end

  ffdsc_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .byte_i   (in_byte_q),
    .result_o (res)
  );

  // result register; dropped hunt bytes leave it empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= fire && res.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res.emit) begin
      res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign data_byte_o    = res_q.data;
  assign byte_index_o   = res_q.index;
  assign frame_end_o    = res_q.frame_end;
  assign frame_status_o = res_q.status;
  assign command_code_o = res_q.command;

endmodule

// File: rtl/ffdsc_parser.sv
// ----------------------------------------------------------------------------
// ffdsc_parser
// Frame position, running sum and held fields; decides the result for one
// byte combinationally.
// ----------------------------------------------------------------------------
module ffdsc_parser import ffdsc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [ByteW-1:0] byte_i,
  output result_t          result_o
);

  logic [IndexW-1:0] pos_q, pos_d;
  logic [ByteW-1:0]  sum_q, sum_d;
  logic [ByteW-1:0]  cmd_q, cmd_d;
  logic [ByteW-1:0]  chk_q, chk_d;
  logic [IndexW-1:0] pos_eff;

  always_comb begin
    pos_d    = pos_q;
    sum_d    = sum_q;
    cmd_d    = cmd_q;
    chk_d    = chk_q;
    result_o = '{emit: 1'b0, data: byte_i, index: '0, frame_end: 1'b0,
                 status: StRun, command: '0};
    // out-of-range position behaves as a fresh hunt
    pos_eff  = (pos_q > LastIndex) ? '0 : pos_q;

    if (pos_eff == '0) begin
      pos_d = '0;
      sum_d = '0;
      chk_d = '0;
      if (byte_i == SyncByte) begin
        sum_d         = byte_i;
        pos_d         = 7'd1;
        result_o.emit = 1'b1;
      end
    end else if (pos_eff >= HdrFirst && pos_eff <= HdrLast &&
                 byte_i != header_byte(pos_eff)) begin
      pos_d              = '0;
      sum_d              = '0;
      chk_d              = '0;
      result_o.emit      = 1'b1;
      result_o.index     = pos_eff;
      result_o.frame_end = 1'b1;
      result_o.status    = StHeader;
    end else if (pos_eff == LastIndex) begin
      pos_d              = '0;
      sum_d              = '0;
      chk_d              = '0;
      result_o.emit      = 1'b1;
      result_o.index     = pos_eff;
      result_o.frame_end = 1'b1;
      result_o.command   = cmd_q;
      if (byte_i != SyncByte) begin
        result_o.status = StTrailer;
      end else if (sum_q != chk_q) begin
        result_o.status = StCheck;
      end else begin
        result_o.status = StGood;
      end
    end else begin
      if (pos_eff < SumEnd) begin
        sum_d = sum_q + byte_i;
      end
      if (pos_eff == CmdIndex) begin
        cmd_d = byte_i;
      end
      if (pos_eff == SumEnd) begin
        chk_d = byte_i;
      end
      pos_d          = pos_eff + 7'd1;
      result_o.emit  = 1'b1;
      result_o.index = pos_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      sum_q <= '0;
      cmd_q <= '0;
      chk_q <= '0;
    end else if (fire_i) begin
      pos_q <= pos_d;
      sum_q <= sum_d;
      cmd_q <= cmd_d;
      chk_q <= chk_d;
    end
  end

endmodule

// File: rtl/ffdsc_checker.sv
// ----------------------------------------------------------------------------
// ffdsc_checker
// Port-level checks on the deframer result stream.
// ----------------------------------------------------------------------------
module ffdsc_checker import ffdsc_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [ByteW-1:0]  data_byte_o,
  input logic [IndexW-1:0] byte_index_o,
  input logic              frame_end_o,
  input logic [2:0]        frame_status_o,
  input logic [ByteW-1:0]  command_code_o
);

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(data_byte_o) &&
    $stable(byte_index_o) && $stable(frame_status_o) && $stable(command_code_o))
    else $error("stalled result changed");

  // status only on frame end, command zero mid-frame
  a_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_end_o |-> frame_status_o == StRun && command_code_o == '0)
    else $error("mid-frame result carries status or command");

  // header abort only at header indices
  a_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o && frame_status_o == StHeader |->
    byte_index_o >= HdrFirst && byte_index_o <= HdrLast && command_code_o == '0)
    else $error("header abort at wrong index");

  // other frame ends only at the last index
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o && frame_status_o != StHeader |->
    byte_index_o == LastIndex &&
    (frame_status_o == StGood || frame_status_o == StTrailer ||
     frame_status_o == StCheck))
    else $error("frame end at wrong index or status");

  // frame start is always the sync byte
  a_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_index_o == '0 |-> data_byte_o == SyncByte && !frame_end_o)
    else $error("frame start without sync byte");

endmodule

bind fixed_frame_deframer_sum_check ffdsc_checker u_ffdsc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .data_byte_o    (data_byte_o),
  .byte_index_o   (byte_index_o),
  .frame_end_o    (frame_end_o),
  .frame_status_o (frame_status_o),
  .command_code_o (command_code_o)
);

// File: dv/frame_result_checker.sv
// ----------------------------------------------------------------------------
// frame_result_checker
// Watches both channels of the frame deframer, predicts every result from
// the accepted bytes and compares each delivered result field by field.
// ----------------------------------------------------------------------------
module frame_result_checker import ffdsc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [ByteW-1:0]  rx_byte_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [ByteW-1:0]  data_byte_i,
  input  logic [IndexW-1:0] byte_index_i,
  input  logic              frame_end_i,
  input  logic [2:0]        frame_status_i,
  input  logic [ByteW-1:0]  command_code_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  // header bytes for indices 2..7, index 2 in the low byte
  localparam logic [47:0] HeaderSeq = {8'd2, 8'd0, 8'd0, 8'd1, 8'd0, 8'd1};

  typedef struct packed {
    logic [ByteW-1:0]  data;
    logic [IndexW-1:0] index;
    logic              last;
    frame_status_e     status;
    logic [ByteW-1:0]  command;
  } frame_byte_t;

  frame_byte_t       expected_bytes_q[$];
  logic [IndexW-1:0] next_pos;
  logic [ByteW-1:0]  sum_acc;
  logic [ByteW-1:0]  cmd_hold;
  logic [ByteW-1:0]  check_hold;
  int unsigned       fails;

  assign fail_count_o = fails;

  task automatic restart_hunt();
    next_pos   = '0;
    sum_acc    = '0;
    check_hold = '0;
  endtask

  // works out what one accepted byte produces and queues it
  task automatic predict_frame_byte(input logic [ByteW-1:0] b);
    frame_byte_t       r;
    logic [IndexW-1:0] p;
    logic              hit;
    p         = next_pos;
    hit       = 1'b1;
    r.data    = b;
    r.index   = p;
    r.last    = 1'b0;
    r.status  = StRun;
    r.command = '0;
    if (p > LastIndex) begin
      restart_hunt();
      p       = '0;
      r.index = '0;
    end
    if (p == '0) begin
      if (b != SyncByte) begin
        hit = 1'b0;
      end else begin
        sum_acc  = b;
        next_pos = 7'd1;
      end
    end else if (p >= HdrFirst && p <= HdrLast &&
                 b != HeaderSeq[int'(p - HdrFirst) * 8 +: 8]) begin
      r.last   = 1'b1;
      r.status = StHeader;
      restart_hunt();
    end else if (p == LastIndex) begin
      r.last    = 1'b1;
      r.command = cmd_hold;
      if (b != SyncByte)           r.status = StTrailer;
      else if (sum_acc != check_hold) r.status = StCheck;
      else                         r.status = StGood;
      restart_hunt();
    end else begin
      if (p < SumEnd)   sum_acc = sum_acc + b;
      if (p == CmdIndex) cmd_hold = b;
      if (p == SumEnd)  check_hold = b;
      next_pos = p + 7'd1;
    end
    if (hit) expected_bytes_q.push_back(r);
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    frame_byte_t e;
    if (!rst_ni) begin
      expected_bytes_q.delete();
      restart_hunt();
      cmd_hold = '0;
      fails    = 0;
    end else begin
      // results first: a result can never stem from a byte taken this edge
      if (out_valid_i && !out_stall_i) begin
        if (expected_bytes_q.size() == 0) begin
          $error("unexpected result: data 0x%0h index %0d", data_byte_i, byte_index_i);
          fails++;
        end else begin
          e = expected_bytes_q.pop_front();
          check_field("data_byte", e.data, data_byte_i);
          check_field("byte_index", e.index, byte_index_i);
          check_field("frame_end", e.last, frame_end_i);
          check_field("frame_status", e.status, frame_status_i);
          check_field("command_code", e.command, command_code_i);
        end
      end
      if (in_valid_i && !in_stall_i) predict_frame_byte(rx_byte_i);
    end
    pending_o <= expected_bytes_q.size();
  end

endmodule

// File: dv/fixed_frame_deframer_sum_check_tb.sv
// ----------------------------------------------------------------------------
// fixed_frame_deframer_sum_check_tb
// Drives received bytes into the deframer and gives the verdict.
// ----------------------------------------------------------------------------
// A short directed run covers hunting noise, header aborts at the first and
// last header index and the rule that an aborting byte never restarts a
// frame. The random run is mostly well formed 65-byte frames (good, bad
// checksum, bad trailer, both) with random or extreme content, mixed with
// noise and frames broken in the header. Both sides insert random idle
// cycles, with stretches of none, and once the receiver holds off long
// enough for the block to fill and stall its input. Prediction and
// comparison live in frame_result_checker.
// ----------------------------------------------------------------------------
module fixed_frame_deframer_sum_check_tb;

  import ffdsc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [47:0] HeaderSeq  = {8'd2, 8'd0, 8'd0, 8'd1, 8'd0, 8'd1};
  localparam int unsigned FrameBytes = 65;
  localparam int unsigned ItemTarget = 1050;
  localparam int unsigned LongHold   = 240;   // cycles of receiver hold-off
  localparam int unsigned DrainLimit = 2000;  // cycles allowed to drain

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              in_valid_i     = 1'b0;
  logic              in_stall_o;
  logic [ByteW-1:0]  rx_byte_i      = '0;
  logic              out_valid_o;
  logic              out_stall_i    = 1'b0;
  logic [ByteW-1:0]  data_byte_o;
  logic [IndexW-1:0] byte_index_o;
  logic              frame_end_o;
  logic [2:0]        frame_status_o;
  logic [ByteW-1:0]  command_code_o;

  int unsigned fail_count;
  int unsigned pending;

  // steady and the hold counts are shared between the stimulus and the receiver process
  bit          steady      = 1'b0;  // no idle cycles on either side
  int unsigned holds_asked = 0;     // written by stimulus only
  int unsigned holds_done  = 0;     // written by receiver only
  int unsigned items_sent  = 0;

  always #4 clk_i = ~clk_i;

  fixed_frame_deframer_sum_check u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .data_byte_o    (data_byte_o),
    .byte_index_o   (byte_index_o),
    .frame_end_o    (frame_end_o),
    .frame_status_o (frame_status_o),
    .command_code_o (command_code_o)
  );

  frame_result_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .data_byte_i    (data_byte_o),
    .byte_index_i   (byte_index_o),
    .frame_end_i    (frame_end_o),
    .frame_status_i (frame_status_o),
    .command_code_i (command_code_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // Offers one byte and returns at the edge of its transfer. With no gap the
  // valid simply stays high, so it gets a single assignment per step.
  task automatic send_byte(input logic [ByteW-1:0] b);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      rx_byte_i  <= 8'($urandom);  // junk while idle
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic logic [ByteW-1:0] not_sync();
    logic [ByteW-1:0] b;
    b = 8'($urandom);
    if (b == SyncByte) b = ~b;
    return b;
  endfunction

  // Full frame; content random, all zero or all ones.
  task automatic send_frame(input bit bad_sum, input bit bad_trailer);
    logic [ByteW-1:0] fr [FrameBytes];
    logic [ByteW-1:0] acc;
    int unsigned      fill;
    fill  = $urandom_range(0, 7);
    fr[0] = SyncByte;
    fr[1] = 8'($urandom);
    for (int i = 2; i <= 7; i++) fr[i] = HeaderSeq[(i - 2) * 8 +: 8];
    for (int i = 8; i < SumEnd; i++) begin
      if (fill == 0)      fr[i] = 8'h00;
      else if (fill == 1) fr[i] = 8'hFF;
      else                fr[i] = 8'($urandom);
    end
    acc = '0;
    for (int i = 0; i < SumEnd; i++) acc = acc + fr[i];
    fr[SumEnd]     = bad_sum ? acc + 8'($urandom_range(1, 255)) : acc;
    fr[SumEnd + 1] = 8'($urandom);  // ignored byte
    fr[LastIndex]  = bad_trailer ? not_sync() : SyncByte;
    for (int i = 0; i < FrameBytes; i++) send_byte(fr[i]);
    items_sent += FrameBytes;
  endtask

  // Frame cut short by a wrong byte at header index 'at'.
  task automatic send_broken(input int unsigned at);
    logic [ByteW-1:0] good;
    logic [ByteW-1:0] bad;
    send_byte(SyncByte);
    send_byte(8'($urandom));
    for (int i = 2; i < at; i++) send_byte(HeaderSeq[(i - 2) * 8 +: 8]);
    good = HeaderSeq[(at - 2) * 8 +: 8];
    bad  = 8'($urandom);
    if (bad == good) bad = bad ^ (8'h01 << $urandom_range(0, 7));
    send_byte(bad);
    items_sent += at + 1;
  endtask

  // Receiver: random stall before each result transfer, plus the long
  // hold-off when asked for, counted here so the sender keeps offering.
  initial begin : receiver
    int unsigned gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (holds_asked != holds_done) begin
        holds_done++;
        gap = LongHold;
      end else begin
        gap = steady ? 0 : $urandom_range(0, 3);
      end
      if (gap != 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin : stimulus
    int unsigned frames;
    int unsigned pick;
    int unsigned waited;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // hunting: none of these start a frame
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h54);
    send_byte(8'hAA);
    // abort at the first header index
    send_byte(SyncByte);
    send_byte(8'hFF);
    send_byte(8'h00);
    // abort at the last header index
    send_byte(SyncByte);
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
    // a sync byte that aborts must not open a new frame: the 0x00 after it
    // has to be dropped
    send_byte(SyncByte);
    send_byte(8'h12);
    send_byte(SyncByte);
    send_byte(8'h00);

    // random part; first four frames cover good, bad checksum, bad trailer and both
    frames = 0;
    while (items_sent < ItemTarget) begin
      steady = ($urandom_range(0, 4) == 0);
      if (frames == 2) holds_asked++;
      if (frames < 4) begin
        send_frame(frames[0], frames[1]);
      end else begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          send_broken($urandom_range(2, 7));
        end else if (pick == 1) begin
          repeat ($urandom_range(1, 6)) send_byte(not_sync());
        end else begin
          send_frame($urandom_range(0, 4) == 0, $urandom_range(0, 4) == 0);
        end
      end
      frames++;
    end
    in_valid_i <= 1'b0;
    steady = 1'b0;

    // drain, then give the block time to flush anything still in flight
    @(posedge clk_i);
    waited = 0;
    while (pending != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (16) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("PASS fixed_frame_deframer_sum_check");
    end else begin
      if (pending != 0) $error("%0d expected results never arrived", pending);
      $display("FAIL fixed_frame_deframer_sum_check");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin : watchdog
    #3_200_000;
    $display("FAIL fixed_frame_deframer_sum_check");
    $finish;
  end

endmodule
